FILE: hw/rtl/sam_pkg.sv
// ----------------------------------------------------------------------------
// sam_pkg: shared types and constants for the approximate shift-and matcher
// Word layouts of both channels and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sam_pkg;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int SYM_W       = 8;
  localparam int START_W     = 32;
  localparam int LENREG_W    = 6;
  localparam int ERRREG_W    = 2;
  localparam int PAT_REGS    = 4;
  localparam int PAT_CHARS   = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PAT_A      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_B      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_C      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_D      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_LENGTH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ERRORS = 3'd5;

  typedef struct packed {
    logic             start_text;
    logic [SYM_W-1:0] symbol;
  } sam_in_t;

  typedef struct packed {
    logic               match_found;
    logic [START_W-1:0] match_start;
  } sam_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/shift_and_approx_match.sv
// ----------------------------------------------------------------------------
// shift_and_approx_match: approximate pattern matcher, one text symbol a word
// Bit-parallel shift-and search with one state vector per error level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries one text symbol a word;
//   start_text marks the first symbol of a new text and reloads the level
//   vectors from the current configuration and restarts the position at zero.
//   Output channel (out_valid/out_ready/out_item) gives one result per
//   symbol: match flag and the text position where the match begins.
//   Configuration (cfg_we/cfg_index/cfg_data) holds the pattern characters,
//   the length and the error count; write it only while no word is in flight.
// Timing:
//   An accepted word passes the input register, then the level chain into
//   the result register; a stalled receiver can hold it in between.
//   Throughput is one word per cycle while out_ready is high; the level update
//   is a single pass of shifts and ORs through all error levels from the
//   state registers. When the receiver stalls, the result register holds and
//   the input register fills; in_ready drops only while both are full.
// Reset:
//   rst clears both registers, the pattern to zero, the length to one, the
//   error count to zero, the level vectors and the position to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_and_approx_match
  import sam_pkg::*;
#(
  parameter int MAX_PATTERN   = 32,
  parameter int MAX_LEVELS    = 4,
  parameter int SYMBOL_BITS   = 8,
  parameter int POSITION_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire sam_in_t                in_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output sam_out_t                    out_item,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int VEC_W   = MAX_PATTERN;
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int ERR_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int DIFF_W  = (POSITION_BITS > START_W) ? POSITION_BITS : START_W;
  localparam int CMP_BITS = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;
  localparam logic [SYM_W-1:0] CMP_MASK = SYM_W'((1 << CMP_BITS) - 1);

  typedef logic [VEC_W-1:0] vec_t;

  // configuration
  logic [CFG_DATA_W-1:0] pat [PAT_REGS];
  logic [LENREG_W-1:0]   pattern_length;
  logic [ERRREG_W-1:0]   max_errors;

  // state
  vec_t                     lv [MAX_LEVELS];
  logic [POSITION_BITS-1:0] pos;

  // pipeline registers
  logic    in_full;
  sam_in_t in_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < PAT_REGS; r++) pat[r] <= '0;
      pattern_length <= LENREG_W'(1);
      max_errors     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_A:      pat[0] <= cfg_data;
        REG_PAT_B:      pat[1] <= cfg_data;
        REG_PAT_C:      pat[2] <= cfg_data;
        REG_PAT_D:      pat[3] <= cfg_data;
        REG_PAT_LENGTH: pattern_length <= cfg_data[LENREG_W-1:0];
        REG_MAX_ERRORS: max_errors <= cfg_data[ERRREG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective length and error count
  logic [LEN_W-1:0] eff_len;
  logic [ERR_W-1:0] eff_errs;
  logic [6:0]       len7;
  logic [6:0]       err7;

  always_comb begin
    if (pattern_length == '0)
      eff_len = LEN_W'(1);
    else if (7'(pattern_length) > 7'(MAX_PATTERN))
      eff_len = LEN_W'(MAX_PATTERN);
    else
      eff_len = LEN_W'(pattern_length);
    len7 = 7'(eff_len);
    err7 = 7'(max_errors);
    if (err7 > len7 - 7'd1) err7 = len7 - 7'd1;
    if (err7 > 7'(MAX_LEVELS - 1)) err7 = 7'(MAX_LEVELS - 1);
    eff_errs = ERR_W'(err7);
  end

  // pattern characters as a flat list
  logic [SYM_W-1:0] chars [PAT_CHARS];
  for (genvar j = 0; j < PAT_CHARS; j++) begin : g_chars
    assign chars[j] = pat[j >> 3][8*(j & 7) +: 8];
  end

  // symbol mask: character i lands on bit len-1-i
  vec_t hit;
  vec_t hit_rev;
  vec_t smask;
  vec_t top;

  always_comb begin
    for (int i = 0; i < VEC_W; i++) begin
      if (i < PAT_CHARS)
        hit[i] = ((chars[5'(i)] ^ in_q.symbol) & CMP_MASK) == '0;
      else
        hit[i] = ((in_q.symbol & CMP_MASK) == '0);
      hit_rev[VEC_W-1-i] = hit[i];
    end
    smask = hit_rev >> (LEN_W'(MAX_PATTERN) - eff_len);
    top   = vec_t'(1) << (eff_len - LEN_W'(1));
  end

  // level chain
  logic advance;
  vec_t init_v [MAX_LEVELS];
  vec_t base   [MAX_LEVELS];
  vec_t lv_next [MAX_LEVELS];
  logic [POSITION_BITS-1:0] pos_use;
  logic [POSITION_BITS-1:0] pos_next;
  logic [DIFF_W-1:0]        diff;
  logic                     match;

  always_comb begin
    vec_t prev;
    vec_t cur;
    vec_t c;
    init_v[0] = '0;
    for (int l = 1; l < MAX_LEVELS; l++) begin
      if (l <= int'(eff_errs))
        init_v[l] = init_v[l-1] | (vec_t'(1) << (eff_len - LEN_W'(l)));
      else
        init_v[l] = '0;
    end
    for (int l = 0; l < MAX_LEVELS; l++)
      base[l] = in_q.start_text ? init_v[l] : lv[l];

    cur        = ((base[0] >> 1) | top) & smask;
    prev       = base[0];
    lv_next[0] = cur;
    for (int l = 1; l < MAX_LEVELS; l++) begin
      c = ((base[l] >> 1) & smask) | prev | ((prev | cur) >> 1);
      if (l <= int'(eff_errs)) begin
        prev       = base[l];
        cur        = c;
        lv_next[l] = c | top;
      end else begin
        lv_next[l] = base[l];
      end
    end

    pos_use  = in_q.start_text ? '0 : pos;
    pos_next = (pos_use != '1) ? pos_use + POSITION_BITS'(1) : pos_use;
    diff     = DIFF_W'(pos_use) - DIFF_W'(eff_len - LEN_W'(1));
    match    = cur[0] && (DIFF_W'(pos_use) >= DIFF_W'(eff_len - LEN_W'(1)));
  end

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
      for (int l = 0; l < MAX_LEVELS; l++) lv[l] <= '0;
    end else begin
      if (in_valid && in_ready)
        in_full <= 1'b1;
      else if (advance)
        in_full <= 1'b0;

      if (advance) begin
        out_valid <= 1'b1;
        pos       <= pos_next;
        for (int l = 0; l < MAX_LEVELS; l++) lv[l] <= lv_next[l];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      in_q <= in_item;
    if (advance) begin
      out_item.match_found <= match;
      out_item.match_start <= match ? diff[START_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sam_checker.sv
// ----------------------------------------------------------------------------
// sam_checker: port-level checks for the approximate shift-and matcher
// Watches the top-level channels and flags stalls or results that go wrong.
// ----------------------------------------------------------------------------
`default_nettype none

module sam_checker
  import sam_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire sam_out_t out_item
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result word changed or dropped");

  // report a start only with a match
  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.match_found |-> out_item.match_start == '0)
    else $error("match_start nonzero without a match");

  // drop input ready only behind a stalled, full result register
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the output side can move");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind shift_and_approx_match sam_checker u_sam_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the approximate shift-and matcher
// Streams directed and random texts through the matcher under several pattern
// settings, predicts every result word in the bench and compares field by
// field, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------

module tb_top;
  import sam_pkg::*;

  localparam int IDLE_PCT       = 23;
  localparam int STALL_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int TEXT_WORDS     = 1300;
  localparam int DRAIN_CYCLES   = 4;
  localparam int LEVELS         = 4;
  localparam int VEC_W          = 32;

  // indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  sam_in_t                in_item   = '0;
  logic                   out_ready = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_ready;
  logic                   out_valid;
  sam_out_t               out_item;

  shift_and_approx_match dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sam_in_t  pending_words[$];
  sam_out_t expected_results[$];
  sam_out_t oldest_result;
  int       fail_count    = 0;
  int       total_words   = 0;
  int       quiet_cycles  = 0;
  int       stall_left    = 0;
  logic     stall_taken   = 1'b0;
  logic     stall_arm     = 1'b0;
  logic     no_idle       = 1'b0;
  logic     start_pending = 1'b0;

  // bench copy of the matcher state and registers
  logic [63:0]      pat_reg [PAT_REGS];
  logic [5:0]       len_reg;
  logic [1:0]       err_reg;
  logic [VEC_W-1:0] level_vec [LEVELS];
  logic [31:0]      text_pos;

  function automatic int unsigned clipped_length(logic [5:0] l);
    if (l == 0) return 1;
    if (l > PAT_CHARS) return PAT_CHARS;
    return 32'(l);
  endfunction

  function automatic int unsigned clipped_errors(int unsigned len);
    int unsigned e;
    e = 32'(err_reg);
    if (e > len - 1) e = len - 1;
    if (e > LEVELS - 1) e = LEVELS - 1;
    return e;
  endfunction

  function automatic void reload_levels();
    int unsigned len;
    int unsigned errs;
    len  = clipped_length(len_reg);
    errs = clipped_errors(len);
    level_vec[0] = '0;
    for (int lvl = 1; lvl < LEVELS; lvl++)
      level_vec[lvl] = (lvl <= errs) ? (level_vec[lvl-1] | (32'd1 << (len - lvl))) : '0;
    text_pos = '0;
  endfunction

  function automatic sam_out_t predict_match(sam_in_t w);
    int unsigned      len;
    int unsigned      errs;
    logic [VEC_W-1:0] smask;
    logic [VEC_W-1:0] top;
    logic [VEC_W-1:0] prev;
    logic [VEC_W-1:0] cur;
    logic [VEC_W-1:0] nxt;
    sam_out_t         res;
    if (w.start_text) reload_levels();
    len   = clipped_length(len_reg);
    errs  = clipped_errors(len);
    smask = '0;
    for (int i = 0; i < len; i++)
      if (pat_reg[i/8][8*(i%8) +: 8] == w.symbol) smask[len-1-i] = 1'b1;
    top  = 32'd1 << (len - 1);
    prev = level_vec[0];
    cur  = ((prev >> 1) | top) & smask;
    level_vec[0] = cur;
    for (int lvl = 1; lvl <= errs; lvl++) begin
      nxt  = ((level_vec[lvl] >> 1) & smask) | prev | ((prev | cur) >> 1);
      prev = level_vec[lvl];
      level_vec[lvl] = nxt | top;
      cur  = nxt;
    end
    res.match_found = cur[0] && (text_pos >= len - 1);
    res.match_start = res.match_found ? text_pos - (len - 1) : '0;
    if (text_pos != '1) text_pos++;
    return res;
  endfunction

  function automatic void push_symbol(logic [SYM_W-1:0] sym);
    sam_in_t w;
    w.start_text = start_pending;
    w.symbol     = sym;
    pending_words.push_back(w);
    start_pending = 1'b0;
    total_words++;
  endfunction

  // sender: hold the word until taken, then offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_match(in_item));
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          in_item  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random idling, plus one long stall to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_arm && !stall_taken) begin
      stall_taken <= 1'b1;
      stall_left  <= STALL_CYCLES;
      out_ready   <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: match_found %0d match_start %0d",
               out_item.match_found, out_item.match_start);
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_item.match_found !== oldest_result.match_found) begin
          $error("match_found: expected %0d, got %0d",
                 oldest_result.match_found, out_item.match_found);
          fail_count++;
        end
        if (out_item.match_start !== oldest_result.match_start) begin
          $error("match_start: expected %0d, got %0d",
                 oldest_result.match_start, out_item.match_start);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PAT_A, REG_PAT_B, REG_PAT_C, REG_PAT_D: pat_reg[idx[1:0]] = data;
      REG_PAT_LENGTH: len_reg = data[LENREG_W-1:0];
      REG_MAX_ERRORS: err_reg = data[ERRREG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d,
                            logic [63:0] len_data, logic [63:0] err_data);
    wait_idle();
    write_reg(REG_PAT_A, a);
    write_reg(REG_PAT_B, b);
    write_reg(REG_PAT_C, c);
    write_reg(REG_PAT_D, d);
    write_reg(REG_PAT_LENGTH, len_data);
    write_reg(REG_MAX_ERRORS, err_data);
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int          phase;
    int          target;
    int          r;
    int          n;
    int          alpha_n;
    int unsigned eff_len;
    logic [7:0]  alpha [4];
    logic [7:0]  pat [PAT_CHARS];
    logic [63:0] regs [PAT_REGS];
    logic [63:0] len_data;

    for (int k = 0; k < PAT_REGS; k++) pat_reg[k] = '0;
    len_reg = 6'd1;
    err_reg = 2'd0;
    reload_levels();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset pattern: a single zero character
    start_pending = 1'b1;
    push_symbol(8'h00);
    push_symbol(8'hFF);
    push_symbol(8'h00);

    // "abcd" with one error: substitution, deletion, insertion
    set_config(64'h64636261, '0, '0, '0, 64'd4, 64'd1);
    start_pending = 1'b1;
    push_symbol("a"); push_symbol("b"); push_symbol("x"); push_symbol("d");
    push_symbol("a"); push_symbol("b"); push_symbol("d");
    push_symbol("a"); push_symbol("b"); push_symbol("c"); push_symbol("c"); push_symbol("d");

    // zero length reads as one; error count clamps to length minus one
    set_config(64'h5A, '0, '0, '0, 64'd0, 64'd3);
    start_pending = 1'b1;
    push_symbol(8'h5A); push_symbol(8'h5A); push_symbol(8'h00);

    // oversized length, all-ones pattern, changed mid-text without a restart
    set_config('1, '1, '1, '1, '1, '1);
    push_symbol(8'hFF); push_symbol(8'hFF); push_symbol(8'h00);

    phase = 0;
    while (total_words < TEXT_WORDS) begin
      alpha_n = $urandom_range(1, 4);
      r = $urandom_range(99);
      for (int k = 0; k < 4; k++)
        alpha[k] = (r < 5) ? 8'h00 : (r < 10) ? 8'hFF : 8'($urandom_range(0, 255));
      for (int k = 0; k < PAT_CHARS; k++) pat[k] = alpha[$urandom_range(0, alpha_n - 1)];
      for (int k = 0; k < PAT_REGS; k++)
        for (int j = 0; j < 8; j++) regs[k][8*j +: 8] = pat[8*k + j];
      len_data = {$urandom, $urandom};
      r = $urandom_range(99);
      if (r < 60) len_data[5:0] = 6'($urandom_range(1, 6));
      else if (r < 80) len_data[5:0] = 6'($urandom_range(7, 16));
      else if (r < 92) len_data[5:0] = 6'($urandom_range(17, 32));
      else if (r < 96) len_data[5:0] = 6'd0;
      else len_data[5:0] = 6'($urandom_range(33, 63));
      eff_len = clipped_length(len_data[5:0]);
      set_config(regs[0], regs[1], regs[2], regs[3], len_data, {$urandom, $urandom});

      no_idle   = (phase == 6);
      stall_arm = (phase == 3);
      target = total_words + (no_idle ? 150 : $urandom_range(20, 45));
      // most texts restart; the rest carry the old vectors into the new setting
      start_pending = ($urandom_range(9) != 0);
      while (total_words < target) begin
        if ($urandom_range(99) < 3) start_pending = 1'b1;
        if ($urandom_range(99) < 75) begin
          // one copy of the pattern with occasional edits
          for (int k = 0; k < eff_len; k++) begin
            r = $urandom_range(99);
            if (r < 6) begin
            end else if (r < 12) begin
              push_symbol(alpha[$urandom_range(0, alpha_n - 1)]);
            end else if (r < 18) begin
              push_symbol(8'($urandom_range(0, 255)));
              push_symbol(pat[k]);
            end else begin
              push_symbol(pat[k]);
            end
          end
        end else begin
          n = $urandom_range(1, 4);
          for (int k = 0; k < n; k++)
            push_symbol($urandom_range(1) ? alpha[$urandom_range(0, alpha_n - 1)]
                                          : 8'($urandom_range(0, 255)));
        end
      end
      phase++;
    end

    wait_idle();
    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sam_pkg.sv
hw/rtl/shift_and_approx_match.sv
hw/rtl/sam_checker.sv
bench/tb_top.sv
